// ===== src/rci_pkg.sv =====
// ----------------------------------------------------------------------------
// rci_pkg
// Widths, curve mode and register codes, and the log2 and quarter-sine tables
// used by the ramp curve interpolator.
// ----------------------------------------------------------------------------
package rci_pkg;

  localparam int TICK_BITS     = 24;
  localparam int FRAC_BITS     = 16;
  localparam int SINE_DEPTH    = 256;
  localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH + 1);
  localparam int VEL_BITS      = 7;
  localparam int MODE_BITS     = 3;
  localparam int LG_BITS       = 19;
  localparam int LG_DEPTH      = 2 ** (VEL_BITS + 1);
  localparam int SINE_BITS     = 16;
  localparam int W_BITS        = 17;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  localparam logic [W_BITS-1:0]    Q_ONE    = W_BITS'(32768);
  localparam logic [FRAC_BITS:0]   FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

  localparam logic [MODE_BITS-1:0] MODE_LINEAR = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXP    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_EIO    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_EIN    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_EOUT   = 3'd4;

  localparam logic [2:0] REG_START_TICK = 3'd0;
  localparam logic [2:0] REG_END_TICK   = 3'd1;
  localparam logic [2:0] REG_START_VEL  = 3'd2;
  localparam logic [2:0] REG_END_VEL    = 3'd3;
  localparam logic [2:0] REG_MODE       = 3'd4;

  // pipeline layout
  localparam int S_PREP   = FRAC_BITS + 1;
  localparam int S_MUL    = FRAC_BITS + 2;
  localparam int S_SRCH0  = FRAC_BITS + 3;
  localparam int NSTAGE   = FRAC_BITS + 3 + VEL_BITS;
  localparam int LATENCY  = NSTAGE + 1;

  typedef logic [LG_BITS-1:0]   lg_tab_t   [LG_DEPTH];
  typedef logic [SINE_BITS-1:0] sine_tab_t [SINE_DEPTH + 1];

  typedef struct packed {
    logic                          done;
    logic                          bypass;
    logic [TICK_BITS:0]            rem;
    logic [FRAC_BITS-1:0]          quo;
    logic [FRAC_BITS+LG_BITS-1:0]  target;
    logic [VEL_BITS-1:0]           m_lin;
    logic [W_BITS-1:0]             w;
    logic [VEL_BITS+W_BITS-1:0]    prod;
    logic [VEL_BITS-1:0]           k;
  } pipe_t;

  function automatic logic [LG_BITS-1:0] lg_q16(input int unsigned x);
    logic [63:0]        y;
    int unsigned        n;
    logic [LG_BITS-1:0] r;
    n = 0;
    if (x == 0) begin
      return '0;
    end
    while ((x >> (n + 1)) != 0) begin
      n++;
    end
    y = 64'(x) << (30 - n);
    r = LG_BITS'(n) << 16;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic lg_tab_t build_lg();
    lg_tab_t tab;
    for (int i = 0; i < LG_DEPTH; i++) begin
      tab[i] = lg_q16(i);
    end
    return tab;
  endfunction

  function automatic logic [SINE_BITS-1:0] qsine(input int unsigned i);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic [63:0]        r;
    a    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
    a2   = (a * a) >> 30;
    term = a;
    s    = signed'(a);
    term = ((term * a2) >> 30) / 6;   s = s - signed'(term);
    term = ((term * a2) >> 30) / 20;  s = s + signed'(term);
    term = ((term * a2) >> 30) / 42;  s = s - signed'(term);
    term = ((term * a2) >> 30) / 72;  s = s + signed'(term);
    term = ((term * a2) >> 30) / 110; s = s - signed'(term);
    term = ((term * a2) >> 30) / 156; s = s + signed'(term);
    if (s < 0) begin
      s = 0;
    end
    r = (unsigned'(s) + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return SINE_BITS'(r);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      tab[i] = qsine(i);
    end
    return tab;
  endfunction

  localparam lg_tab_t   LG_TABLE   = build_lg();
  localparam sine_tab_t SINE_TABLE = build_sine();

endpackage

// ===== src/ramp_curve_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// ramp_curve_interpolator_core
// Pipelined velocity ramp evaluator: linear, exponential and sine curves.
// ----------------------------------------------------------------------------
//  channel   signals                                  transfer when
//  query     start, busy, current_tick_i              start && !busy
//  result    valid_o, velocity_o, ramp_done_o         valid_o (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,    psel && penable && pwrite
//            prdata, pready
//
// One query per cycle; busy stays low. The pipeline is a one-bit-per-stage
// divider for the elapsed fraction, then a seven-stage binary search over
// the log2 table for the exponential curve. Reset clears the configuration
// registers and the valid bits, not the stage data. Results cannot be
// stalled, so the pipeline never holds.
module ramp_curve_interpolator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [rci_pkg::TICK_BITS-1:0]       current_tick_i,
  output logic                                valid_o,
  output logic [rci_pkg::VEL_BITS-1:0]        velocity_o,
  output logic                                ramp_done_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rci_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rci_pkg::DATA_BITS-1:0]       pwdata,
  output logic [rci_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);
  import rci_pkg::*;

  logic [TICK_BITS-1:0] start_tick_q, end_tick_q;
  logic [VEL_BITS-1:0]  start_vel_q, end_vel_q;
  logic [MODE_BITS-1:0] mode_q;

  logic                 st_valid_q [NSTAGE];
  pipe_t                st_q       [NSTAGE];
  pipe_t                st_d       [NSTAGE];

  logic                 valid_q, done_q;
  logic [VEL_BITS-1:0]  vel_q, vel_d;

  logic [TICK_BITS-1:0] len;
  logic                 rising;
  logic [VEL_BITS-1:0]  dvel;
  logic                 wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign len    = end_tick_q - start_tick_q;
  assign rising = end_vel_q > start_vel_q;
  assign dvel   = rising ? end_vel_q - start_vel_q : start_vel_q - end_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_tick_q <= '0;
      end_tick_q   <= '0;
      start_vel_q  <= '0;
      end_vel_q    <= '0;
      mode_q       <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_START_TICK: start_tick_q <= pwdata[TICK_BITS-1:0];
        REG_END_TICK:   end_tick_q   <= pwdata[TICK_BITS-1:0];
        REG_START_VEL:  start_vel_q  <= pwdata[VEL_BITS-1:0];
        REG_END_VEL:    end_vel_q    <= pwdata[VEL_BITS-1:0];
        REG_MODE:       mode_q       <= pwdata[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_TICK: prdata = DATA_BITS'(start_tick_q);
      REG_END_TICK:   prdata = DATA_BITS'(end_tick_q);
      REG_START_VEL:  prdata = DATA_BITS'(start_vel_q);
      REG_END_VEL:    prdata = DATA_BITS'(end_vel_q);
      REG_MODE:       prdata = DATA_BITS'(mode_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    logic [TICK_BITS:0]                r2;
    logic [FRAC_BITS-1:0]              f;
    logic [VEL_BITS+FRAC_BITS-1:0]     pl;
    logic [FRAC_BITS:0]                h;
    logic [FRAC_BITS:0]                x;
    logic [FRAC_BITS+SINE_IDX_BITS:0]  xs;
    logic [SINE_IDX_BITS-1:0]          idx;
    logic [W_BITS-1:0]                 q;
    logic [VEL_BITS-1:0]               c;
    logic [VEL_BITS:0]                 ci;
    pipe_t                             p;

    p        = '0;
    p.done   = current_tick_i >= end_tick_q;
    p.bypass = (current_tick_i < start_tick_q) || (start_vel_q == end_vel_q) ||
               (start_tick_q == end_tick_q);
    p.rem    = {1'b0, current_tick_i - start_tick_q};
    st_d[0]  = p;

    for (int i = 1; i <= FRAC_BITS; i++) begin
      p  = st_q[i-1];
      r2 = {p.rem[TICK_BITS-1:0], 1'b0};
      if (r2 >= {1'b0, len}) begin
        p.rem = r2 - {1'b0, len};
        p.quo = {p.quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        p.rem = r2;
        p.quo = {p.quo[FRAC_BITS-2:0], 1'b0};
      end
      st_d[i] = p;
    end

    p        = st_q[S_PREP-1];
    f        = p.quo;
    pl       = (VEL_BITS+FRAC_BITS)'(dvel) * (VEL_BITS+FRAC_BITS)'(f);
    p.m_lin  = pl[VEL_BITS+FRAC_BITS-1:FRAC_BITS];
    p.target = (FRAC_BITS+LG_BITS)'(f) *
               (FRAC_BITS+LG_BITS)'(LG_TABLE[{1'b0, dvel} + 1'b1]);
    h        = {f, 1'b0};
    case (mode_q)
      MODE_EIO:  x = (h < FRAC_ONE) ? FRAC_ONE - h : h - FRAC_ONE;
      MODE_EIN:  x = FRAC_ONE - {1'b0, f};
      default:   x = {1'b0, f};
    endcase
    xs  = (FRAC_BITS+SINE_IDX_BITS+1)'(x) *
          (FRAC_BITS+SINE_IDX_BITS+1)'(SINE_DEPTH);
    idx = SINE_IDX_BITS'(xs >> FRAC_BITS);
    q   = W_BITS'(SINE_TABLE[idx]);
    case (mode_q)
      MODE_EIO:  p.w = (h < FRAC_ONE) ? Q_ONE - q : Q_ONE + q;
      MODE_EIN:  p.w = Q_ONE - q;
      default:   p.w = q;
    endcase
    p.k = '0;
    st_d[S_PREP] = p;

    p      = st_q[S_MUL-1];
    p.prod = (VEL_BITS+W_BITS)'(dvel) * (VEL_BITS+W_BITS)'(p.w);
    st_d[S_MUL] = p;

    for (int j = 0; j < VEL_BITS; j++) begin
      p  = st_q[S_SRCH0+j-1];
      c  = p.k | (VEL_BITS'(1) << (VEL_BITS - 1 - j));
      ci = {1'b0, c} + 1'b1;
      if (c <= dvel && {LG_TABLE[ci], {FRAC_BITS{1'b0}}} <= p.target) begin
        p.k = c;
      end
      st_d[S_SRCH0+j] = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTAGE; i++) begin
        st_valid_q[i] <= 1'b0;
      end
    end else begin
      st_valid_q[0] <= start && !busy;
      for (int i = 1; i < NSTAGE; i++) begin
        st_valid_q[i] <= st_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTAGE; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  always_comb begin
    logic [VEL_BITS:0] m;
    pipe_t             p;
    p = st_q[NSTAGE-1];
    case (mode_q)
      MODE_EXP:            m = {1'b0, p.k};
      MODE_EIO:            m = (VEL_BITS+1)'(p.prod >> 16);
      MODE_EIN, MODE_EOUT: m = (VEL_BITS+1)'(p.prod >> 15);
      default:             m = {1'b0, p.m_lin};
    endcase
    if (m > {1'b0, dvel}) begin
      m = {1'b0, dvel};
    end
    if (p.done) begin
      vel_d = end_vel_q;
    end else if (p.bypass) begin
      vel_d = start_vel_q;
    end else if (rising) begin
      vel_d = start_vel_q + m[VEL_BITS-1:0];
    end else begin
      vel_d = start_vel_q - m[VEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= st_valid_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    vel_q  <= vel_d;
    done_q <= st_q[NSTAGE-1].done;
  end

  assign valid_o     = valid_q;
  assign velocity_o  = vel_q;
  assign ramp_done_o = done_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY valid_o)
    else $error("result missing after query transfer");

  a_done_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ramp_done_o |-> velocity_o == end_vel_q)
    else $error("finished ramp must report end velocity");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ramp_done_o |->
      (rising ? (velocity_o >= start_vel_q && velocity_o <= end_vel_q)
              : (velocity_o <= start_vel_q && velocity_o >= end_vel_q)))
    else $error("velocity outside ramp range");

endmodule

// ===== verif/ramp_velocity_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ramp_velocity_checker
// Watches ramp configuration writes, query transfers and result strobes.
// Computes the expected velocity and done flag for every query in fixed point
// and compares them in order with the results from the interpolator.
// ----------------------------------------------------------------------------
module ramp_velocity_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic                             busy,
  input  logic [rci_pkg::TICK_BITS-1:0]    current_tick_i,
  input  logic                             valid_o,
  input  logic [rci_pkg::VEL_BITS-1:0]     velocity_o,
  input  logic                             ramp_done_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rci_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [rci_pkg::DATA_BITS-1:0]    pwdata,
  input  logic                             pready,
  output int                               fail_count,
  output int                               pending_count,
  output int                               result_count
);
  import rci_pkg::*;

  typedef struct packed {
    logic [VEL_BITS-1:0] vel;
    logic                done;
  } ramp_answer_t;

  logic [TICK_BITS-1:0] cfg_start_tick;
  logic [TICK_BITS-1:0] cfg_end_tick;
  logic [VEL_BITS-1:0]  cfg_start_vel;
  logic [VEL_BITS-1:0]  cfg_end_vel;
  logic [MODE_BITS-1:0] cfg_mode;
  ramp_answer_t         answer_q[$];

  function automatic longint unsigned log2_fix(input longint unsigned x);
    longint unsigned n;
    longint unsigned y;
    longint unsigned r;
    n = 0;
    if (x == 0) begin
      return 0;
    end
    while ((x >> (n + 1)) != 0) begin
      n++;
    end
    y = x << (30 - n);
    r = n << 16;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic longint unsigned sine_quarter(input longint unsigned idx);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          acc;
    longint unsigned r;
    bit              neg;
    neg = 1'b1;
    if (idx > SINE_DEPTH) begin
      idx = SINE_DEPTH;
    end
    a = (64'd1686629713 * idx) / SINE_DEPTH;
    a2 = (a * a) >> 30;
    term = a;
    acc = longint'(a);
    for (longint unsigned n = 3; n <= 13; n += 2) begin
      term = ((term * a2) >> 30) / ((n - 1) * n);
      acc = neg ? acc - longint'(term) : acc + longint'(term);
      neg = !neg;
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (longint'(acc) + 16384) >> 15;
    return (r > 32768) ? 32768 : r;
  endfunction

  function automatic longint unsigned sine_of_frac(input longint unsigned frac);
    return sine_quarter((frac * SINE_DEPTH) >> FRAC_BITS);
  endfunction

  function automatic longint unsigned curve_step(input logic [MODE_BITS-1:0] mode,
                                                 input longint unsigned span,
                                                 input longint unsigned frac);
    longint unsigned one;
    longint unsigned w;
    longint unsigned h;
    longint unsigned k;
    longint unsigned goal;
    one = 64'd1 << FRAC_BITS;
    case (mode)
      MODE_EXP: begin
        goal = frac * log2_fix(span + 1);
        k = 0;
        while (k < span && (log2_fix(k + 2) << FRAC_BITS) <= goal) begin
          k++;
        end
        return k;
      end
      MODE_EIO: begin
        h = frac << 1;
        if (h < one) begin
          w = 32768 - sine_of_frac(one - h);
        end else begin
          w = 32768 + sine_of_frac(h - one);
        end
        return (span * w) >> 16;
      end
      MODE_EIN: return (span * (32768 - sine_of_frac(one - frac))) >> 15;
      MODE_EOUT: return (span * sine_of_frac(frac)) >> 15;
      default: return (span * frac) >> FRAC_BITS;
    endcase
  endfunction

  function automatic ramp_answer_t velocity_at(input logic [TICK_BITS-1:0] tick);
    ramp_answer_t    ans;
    longint unsigned len;
    longint unsigned frac;
    longint unsigned span;
    longint unsigned mag;
    ans.done = 1'b0;
    if (tick >= cfg_end_tick) begin
      ans.vel = cfg_end_vel;
      ans.done = 1'b1;
      return ans;
    end
    if (tick < cfg_start_tick || cfg_start_vel == cfg_end_vel ||
        cfg_start_tick == cfg_end_tick) begin
      ans.vel = cfg_start_vel;
      return ans;
    end
    len = cfg_end_tick - cfg_start_tick;
    frac = (longint'(tick - cfg_start_tick) << FRAC_BITS) / len;
    if (cfg_end_vel > cfg_start_vel) begin
      span = cfg_end_vel - cfg_start_vel;
    end else begin
      span = cfg_start_vel - cfg_end_vel;
    end
    mag = curve_step(cfg_mode, span, frac);
    if (mag > span) begin
      mag = span;
    end
    if (cfg_end_vel > cfg_start_vel) begin
      ans.vel = VEL_BITS'(cfg_start_vel + mag);
    end else begin
      ans.vel = VEL_BITS'(cfg_start_vel - mag);
    end
    return ans;
  endfunction

  assign pending_count = answer_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ramp_answer_t exp_ans;
    if (!rst_ni) begin
      cfg_start_tick <= '0;
      cfg_end_tick   <= '0;
      cfg_start_vel  <= '0;
      cfg_end_vel    <= '0;
      cfg_mode       <= '0;
      fail_count     <= 0;
      result_count   <= 0;
      answer_q.delete();
    end else begin
      if (start && !busy) begin
        answer_q.insert(answer_q.size(), velocity_at(current_tick_i));
      end
      if (valid_o) begin
        result_count <= result_count + 1;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result vel=%0d done=%0b", $time, velocity_o,
                   ramp_done_o);
          fail_count <= fail_count + 1;
        end else begin
          exp_ans = answer_q.pop_front();
          if (exp_ans.vel !== velocity_o || exp_ans.done !== ramp_done_o) begin
            $display("%0t: mismatch expected vel=%0d done=%0b actual vel=%0d done=%0b",
                     $time, exp_ans.vel, exp_ans.done, velocity_o, ramp_done_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_START_TICK: cfg_start_tick <= pwdata[TICK_BITS-1:0];
          REG_END_TICK:   cfg_end_tick   <= pwdata[TICK_BITS-1:0];
          REG_START_VEL:  cfg_start_vel  <= pwdata[VEL_BITS-1:0];
          REG_END_VEL:    cfg_end_vel    <= pwdata[VEL_BITS-1:0];
          REG_MODE:       cfg_mode       <= pwdata[MODE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_ramp_curve_interpolator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ramp_curve_interpolator_core
// Drives ramp settings over the register port and streams tick queries with
// random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ramp_curve_interpolator_core;
  import rci_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TICK_BITS-1:0] current_tick_i = '0;
  logic                 valid_o;
  logic [VEL_BITS-1:0]  velocity_o;
  logic                 ramp_done_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending_count;
  int                   result_count;
  int                   cycle_count = 0;
  int                   query_count = 0;
  int                   settings_count = 0;
  int                   gap_pct = 0;
  logic [TICK_BITS-1:0] ramp_lo;
  logic [TICK_BITS-1:0] ramp_hi;

  always #1 clk_i = ~clk_i;

  ramp_curve_interpolator_core u_dut (.*);

  ramp_velocity_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_BITS'({idx, 2'b00});
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_ramp(input logic [TICK_BITS-1:0] t0, input logic [TICK_BITS-1:0] t1,
                          input logic [VEL_BITS-1:0] v0, input logic [VEL_BITS-1:0] v1,
                          input logic [MODE_BITS-1:0] mode);
    wait (pending_count == 0);
    repeat (LATENCY + 4) @(negedge clk_i);
    reg_write(REG_START_TICK, DATA_BITS'(t0));
    reg_write(REG_END_TICK, DATA_BITS'(t1));
    reg_write(REG_START_VEL, DATA_BITS'(v0));
    reg_write(REG_END_VEL, DATA_BITS'(v1));
    reg_write(REG_MODE, DATA_BITS'(mode));
    ramp_lo = t0;
    ramp_hi = t1;
    settings_count++;
  endtask

  // busy is sampled at the rising edge; start is held until accepted
  task automatic send_tick(input logic [TICK_BITS-1:0] tick);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    current_tick_i = tick;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    query_count++;
  endtask

  task automatic idle_start();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  function automatic logic [TICK_BITS-1:0] pick_tick();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (ramp_hi > ramp_lo && sel < 8) begin
      return ramp_lo + TICK_BITS'($urandom_range(ramp_hi - ramp_lo - 1, 0));
    end else if (sel == 8) begin
      return TICK_BITS'($urandom());
    end
    return (sel == 9 && ramp_lo > 0) ? ramp_lo - 1'b1 : ramp_hi;
  endfunction

  task automatic random_ramp();
    logic [TICK_BITS-1:0] t0;
    logic [TICK_BITS-1:0] len;
    int unsigned          kind;
    kind = $urandom_range(9, 0);
    t0 = TICK_BITS'($urandom());
    len = (kind < 6) ? TICK_BITS'($urandom_range(3000, 1)) : TICK_BITS'($urandom());
    if (kind == 9) begin
      len = '0;
    end
    if (t0 + len < t0) begin
      t0 = '1 - len;
    end
    set_ramp(t0, t0 + len, VEL_BITS'($urandom()), VEL_BITS'($urandom()),
             MODE_BITS'($urandom_range(7, 0)));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: all ticks at or past the end
    send_tick('0);
    send_tick('1);
    idle_start();
    for (int m = 0; m < 8; m++) begin
      set_ramp(24'd100, 24'd1100, 7'd0, 7'd127, MODE_BITS'(m));
      send_tick(24'd99);
      send_tick(24'd100);
      send_tick(24'd600);
      send_tick(24'd1099);
      send_tick(24'd1100);
      idle_start();
    end
    set_ramp(24'd0, 24'hFFFFFF, 7'd127, 7'd0, MODE_EXP);
    send_tick(24'd0);
    send_tick(24'h7FFFFF);
    send_tick(24'hFFFFFE);
    idle_start();
    set_ramp(24'd500, 24'd10, 7'd5, 7'd90, MODE_EIO);
    send_tick(24'd20);
    send_tick(24'd600);
    idle_start();
    set_ramp(24'd10, 24'd10, 7'd40, 7'd40, MODE_LINEAR);
    send_tick(24'd9);
    idle_start();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 0) ? 0 : (ph == 3 ? 36 : 56);
      for (int r = 0; r < 13; r++) begin
        random_ramp();
        for (int i = 0; i < 8; i++) begin
          send_tick(pick_tick());
        end
        idle_start();
      end
    end
    set_ramp(24'd0, 24'd200, 7'd127, 7'd0, MODE_EOUT);
    wait (pending_count == 0);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("queries %0d, results %0d, ramp settings %0d across all curve modes",
             query_count, result_count, settings_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rci_pkg.sv
src/ramp_curve_interpolator_core.sv
verif/ramp_velocity_checker.sv
verif/tb_ramp_curve_interpolator_core.sv
